/* rtl/hlt_pkg.sv */
package hlt_pkg;

    localparam int ENTRIES  = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int PORT_W   = 16;
    localparam int SECS_W   = 16;
    localparam int TIMER_W  = 17;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int RCNT_W   = 6;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
    localparam logic [OP_W-1:0] OP_RELAY     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_HB    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_REFRESH = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NEW     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] port;
        logic [SECS_W-1:0] secs;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic found;
        t_idx idx;
    } t_find;

    // lowest set bit
    function automatic t_find first_set(input logic [ENTRIES-1:0] v);
        t_find f;
        f.found = 1'b0;
        f.idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                f.found = 1'b1;
                f.idx   = IDX_W'(i);
            end
        end
        return f;
    endfunction

    // bits strictly above idx
    function automatic logic [ENTRIES-1:0] above_mask(input t_idx idx);
        logic [ENTRIES-1:0] m;
        for (int i = 0; i < ENTRIES; i++) begin
            m[i] = (i > int'(idx));
        end
        return m;
    endfunction

endpackage

/* rtl/hlt_ram.sv */
module hlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/hlt_front.sv */
module hlt_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [hlt_pkg::OP_W-1:0]   i_operation,
    input  logic [hlt_pkg::PORT_W-1:0] i_port,
    input  logic [hlt_pkg::SECS_W-1:0] i_seconds,
    input  logic                       i_q_full,
    output hlt_pkg::t_push             o_push
);

    logic          r_vld;
    logic          n_vld;
    hlt_pkg::t_cmd r_cmd;
    logic          fwd;
    logic          take;

    // staged transaction moves on when the queue has room
    assign fwd        = r_vld && !i_q_full;
    assign o_in_ready = !r_vld || fwd;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_vld = r_vld;
        if (fwd) begin
            n_vld = 1'b0;
        end
        // unused operation code is dropped here
        if (take && (i_operation != hlt_pkg::OP_UNUSED)) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (take) begin
            r_cmd.op   <= i_operation;
            r_cmd.port <= i_port;
            r_cmd.secs <= i_seconds;
        end
    end

    assign o_push.push = fwd;
    assign o_push.cmd  = r_cmd;

endmodule

/* rtl/hlt_queue.sv */
module hlt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hlt_pkg::t_push i_push,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_vld,
    output hlt_pkg::t_cmd  o_cmd
);

    hlt_pkg::t_cmd                 r_mem [hlt_pkg::QDEPTH];
    logic [hlt_pkg::QPTR_W-1:0]    r_wp;
    logic [hlt_pkg::QPTR_W-1:0]    r_rp;
    logic [hlt_pkg::QCNT_W-1:0]    r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_cnt == hlt_pkg::QCNT_W'(hlt_pkg::QDEPTH));
    assign o_vld   = (r_cnt != '0);
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_vld;
    assign o_cmd   = r_mem[r_rp];

    function automatic logic [hlt_pkg::QPTR_W-1:0] ptr_inc(
        input logic [hlt_pkg::QPTR_W-1:0] p
    );
        logic [hlt_pkg::QPTR_W-1:0] q;
        if (p == hlt_pkg::QPTR_W'(hlt_pkg::QDEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (do_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

endmodule

/* rtl/hlt_back.sv */
module hlt_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_vld,
    input  hlt_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [hlt_pkg::KIND_W-1:0]   o_kind,
    output logic [hlt_pkg::STATUS_W-1:0] o_status,
    output logic [hlt_pkg::SLOT_W-1:0]   o_slot,
    output logic [hlt_pkg::PORT_W-1:0]   o_dest_port,
    output logic [hlt_pkg::RCNT_W-1:0]   o_relay_count,
    output logic                         o_last
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_HB_RD    = 4'd1;
    localparam logic [3:0] S_HB_EV    = 4'd2;
    localparam logic [3:0] S_HB_OUT   = 4'd3;
    localparam logic [3:0] S_TK_RD    = 4'd4;
    localparam logic [3:0] S_TK_EV    = 4'd5;
    localparam logic [3:0] S_RL_RD    = 4'd6;
    localparam logic [3:0] S_RL_EV    = 4'd7;
    localparam logic [3:0] S_RL_EMPTY = 4'd8;

    logic [3:0]                     r_state, n_state;
    hlt_pkg::t_idx                  r_idx, n_idx;
    hlt_pkg::t_idx                  r_hit, n_hit;
    logic [hlt_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [hlt_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    hlt_pkg::t_cmd                  r_cmd, n_cmd;
    logic [hlt_pkg::ENTRIES-1:0]    r_alive, n_alive;
    logic [hlt_pkg::ENTRIES-1:0]    r_pv, n_pv;

    logic                           r_out_vld;
    logic [hlt_pkg::KIND_W-1:0]     r_out_kind, n_out_kind;
    logic [hlt_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    hlt_pkg::t_idx                  r_out_slot, n_out_slot;
    logic [hlt_pkg::PORT_W-1:0]     r_out_port, n_out_port;
    logic [hlt_pkg::CNT_W-1:0]      r_out_cnt, n_out_cnt;
    logic                           r_out_last, n_out_last;
    logic                           load;
    logic                           out_free;

    logic                           rd_en;
    logic                           pwe;
    logic                           twe;
    hlt_pkg::t_idx                  t_waddr;
    logic [hlt_pkg::TIMER_W-1:0]    t_wdata;
    logic [hlt_pkg::PORT_W-1:0]     p_rdata;
    logic [hlt_pkg::TIMER_W-1:0]    t_rdata;
    logic [hlt_pkg::PORT_W-1:0]     port_eff;
    logic [hlt_pkg::TIMER_W-1:0]    secs_ext;

    hlt_pkg::t_find                 f_alive;
    hlt_pkg::t_find                 f_dead;
    hlt_pkg::t_find                 f_next;

    hlt_ram #(.WIDTH(hlt_pkg::PORT_W), .DEPTH(hlt_pkg::ENTRIES)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (pwe),
        .i_waddr (r_hit),
        .i_wdata (r_cmd.port),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (p_rdata)
    );

    hlt_ram #(.WIDTH(hlt_pkg::TIMER_W), .DEPTH(hlt_pkg::ENTRIES)) u_timer_ram (
        .i_clk   (i_clk),
        .i_we    (twe),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (t_rdata)
    );

    assign out_free = !r_out_vld || i_out_ready;
    // a port never written reads as zero
    assign port_eff = r_pv[r_idx] ? p_rdata : '0;
    assign secs_ext = {1'b0, r_cmd.secs};
    assign f_alive  = hlt_pkg::first_set(r_alive);
    assign f_dead   = hlt_pkg::first_set(~r_alive);
    assign f_next   = hlt_pkg::first_set(r_alive & hlt_pkg::above_mask(r_idx));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_status     = r_status;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_alive      = r_alive;
        n_pv         = r_pv;
        o_q_pop      = 1'b0;
        rd_en        = 1'b0;
        pwe          = 1'b0;
        twe          = 1'b0;
        t_waddr      = r_idx;
        t_wdata      = '0;
        load         = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_port   = r_out_port;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_cnt   = '0;
                    case (i_q_cmd.op)
                        hlt_pkg::OP_HEARTBEAT: begin
                            n_idx   = '0;
                            n_state = S_HB_RD;
                        end
                        hlt_pkg::OP_TICK: begin
                            if (f_alive.found) begin
                                n_idx   = f_alive.idx;
                                n_state = S_TK_RD;
                            end
                        end
                        hlt_pkg::OP_RELAY: begin
                            if (f_alive.found) begin
                                n_idx   = f_alive.idx;
                                n_state = S_RL_RD;
                            end else begin
                                n_state = S_RL_EMPTY;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HB_RD: begin
                rd_en   = 1'b1;
                n_state = S_HB_EV;
            end
            S_HB_EV: begin
                if (port_eff == r_cmd.port) begin
                    n_hit    = r_idx;
                    n_status = hlt_pkg::STAT_REFRESH;
                    n_state  = S_HB_OUT;
                end else if (r_idx == hlt_pkg::IDX_W'(hlt_pkg::ENTRIES - 1)) begin
                    n_state = S_HB_OUT;
                    if (f_dead.found) begin
                        n_hit    = f_dead.idx;
                        n_status = hlt_pkg::STAT_NEW;
                    end else begin
                        n_hit    = '0;
                        n_status = hlt_pkg::STAT_FULL;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_HB_RD;
                end
            end
            S_HB_OUT: begin
                if (out_free) begin
                    load         = 1'b1;
                    n_out_kind   = hlt_pkg::KIND_HB;
                    n_out_status = r_status;
                    n_out_slot   = r_hit;
                    n_out_port   = '0;
                    n_out_cnt    = '0;
                    n_out_last   = 1'b1;
                    if (r_status != hlt_pkg::STAT_FULL) begin
                        pwe            = 1'b1;
                        twe            = 1'b1;
                        t_waddr        = r_hit;
                        t_wdata        = {r_cmd.secs, 1'b0};
                        n_pv[r_hit]    = 1'b1;
                        n_alive[r_hit] = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_TK_RD: begin
                rd_en   = 1'b1;
                n_state = S_TK_EV;
            end
            S_TK_EV: begin
                // zero timer is left alone
                if (t_rdata != '0) begin
                    twe = 1'b1;
                    if (secs_ext >= t_rdata) begin
                        t_wdata        = '0;
                        n_alive[r_idx] = 1'b0;
                    end else begin
                        t_wdata = t_rdata - secs_ext;
                    end
                end
                if (f_next.found) begin
                    n_idx   = f_next.idx;
                    n_state = S_TK_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RL_RD: begin
                rd_en   = 1'b1;
                n_state = S_RL_EV;
            end
            S_RL_EV: begin
                if (out_free) begin
                    load         = 1'b1;
                    n_out_kind   = hlt_pkg::KIND_DEST;
                    n_out_status = hlt_pkg::STAT_REFRESH;
                    n_out_slot   = r_idx;
                    n_out_port   = port_eff;
                    n_out_last   = !f_next.found;
                    n_out_cnt    = f_next.found ? '0 : (r_cnt + 1'b1);
                    n_cnt        = r_cnt + 1'b1;
                    if (f_next.found) begin
                        n_idx   = f_next.idx;
                        n_state = S_RL_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RL_EMPTY: begin
                if (out_free) begin
                    load         = 1'b1;
                    n_out_kind   = hlt_pkg::KIND_EMPTY;
                    n_out_status = hlt_pkg::STAT_REFRESH;
                    n_out_slot   = '0;
                    n_out_port   = '0;
                    n_out_cnt    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alive   <= '0;
            r_pv      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alive <= n_alive;
            r_pv    <= n_pv;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_cnt        <= n_cnt;
        r_cmd        <= n_cmd;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_port   <= n_out_port;
        r_out_cnt    <= n_out_cnt;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_vld;
    assign o_kind        = r_out_kind;
    assign o_status      = r_out_status;
    assign o_slot        = hlt_pkg::SLOT_W'(r_out_slot);
    assign o_dest_port   = r_out_port;
    assign o_relay_count = hlt_pkg::RCNT_W'(r_out_cnt);
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    a_alive_has_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alive & ~r_pv) == '0)
        else $error("alive slot without a written port");

    a_relay_lists_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RL_EV && out_free) |-> r_alive[r_idx])
        else $error("relay listed a dead slot");

    a_hb_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_q_vld && i_q_cmd.op == hlt_pkg::OP_HEARTBEAT)
        |=> (r_state == S_HB_RD && r_idx == '0))
        else $error("heartbeat did not start its scan at slot zero");

    a_non_last_is_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> (r_out_kind == hlt_pkg::KIND_DEST))
        else $error("non-final result that is not a relay destination");
`endif

endmodule

/* rtl/heartbeat_liveness_table.sv */
// Keepalive table of hlt_pkg::ENTRIES port slots, each with a 17-bit countdown
// timer and an alive mark, empty after reset (per-slot valid bits, no clearing
// pass). Operation 0 (heartbeat) refreshes the lowest slot whose port matches,
// else takes the lowest dead slot, loading twice the interval; it answers with
// one result (status refreshed, new or table full). Operation 1 (tick) takes
// the elapsed seconds from every alive slot with a nonzero timer and gives no
// result. Operation 2 (relay) lists every alive slot in index order, with the
// count on the last result, or one empty result. Code 3 is dropped. Port and
// timer live in single-read-port RAMs, so every visited slot passes a read
// state and then an evaluation state; the port scan of a heartbeat stops at
// the first match, and a heartbeat and a relay also wait on the result side.
// A two-deep queue buffers transactions in front of the table.
module heartbeat_liveness_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [hlt_pkg::OP_W-1:0]     i_operation,
    input  logic [hlt_pkg::PORT_W-1:0]   i_port,
    input  logic [hlt_pkg::SECS_W-1:0]   i_seconds,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [hlt_pkg::KIND_W-1:0]   o_kind,
    output logic [hlt_pkg::STATUS_W-1:0] o_status,
    output logic [hlt_pkg::SLOT_W-1:0]   o_slot,
    output logic [hlt_pkg::PORT_W-1:0]   o_dest_port,
    output logic [hlt_pkg::RCNT_W-1:0]   o_relay_count,
    output logic                         o_last
);

    hlt_pkg::t_push push;
    logic           q_full;
    logic           q_vld;
    logic           q_pop;
    hlt_pkg::t_cmd  q_cmd;

    hlt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_port      (i_port),
        .i_seconds   (i_seconds),
        .i_q_full    (q_full),
        .o_push      (push)
    );

    hlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd)
    );

    hlt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_vld       (q_vld),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_dest_port   (o_dest_port),
        .o_relay_count (o_relay_count),
        .o_last        (o_last)
    );

endmodule
